/* hdl/i2cm_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// i2cm_pkg: shared types and constants of the I2C master byte engine
// Command codes, queue entry layout, timing register block and bus opcodes.
// ============================================================================
package i2cm_pkg;

    localparam int TIMER_W     = 10;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    // Bus opcodes as they arrive on the op field
    localparam logic [2:0] OP_START = 3'd0;
    localparam logic [2:0] OP_STOP  = 3'd1;
    localparam logic [2:0] OP_WRITE = 3'd2;
    localparam logic [2:0] OP_READ  = 3'd3;
    localparam logic [2:0] OP_ADDR  = 3'd4;

    // Register indexes (paddr bit 2 selects the word)
    localparam logic REG_HALF_PERIOD = 1'b0;
    localparam logic REG_HIGH_HOLD   = 1'b1;

    localparam logic [TIMER_W-1:0] HALF_PERIOD_RST = 10'd47;
    localparam logic [TIMER_W-1:0] HIGH_HOLD_RST   = 10'd40;

    localparam logic [7:0] BYTE_ONES = 8'hff;

    // Classified command; the front maps unknown ops and idle ticks to CMD_NONE
    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4,
        CMD_ADDR  = 3'd5
    } t_cmd;

    // One tick as it travels from front to back
    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] data;      // first byte to shift: tx byte, address+rw, or all ones
        logic       send_ack;
        logic       sda;
        logic       scl;
    } t_item;

    typedef struct packed {
        logic [TIMER_W-1:0] half_period;
        logic [TIMER_W-1:0] high_hold;
    } t_cfg;

endpackage

/* hdl/i2cm_front.sv */
`timescale 1ns / 1ps
// ============================================================================
// i2cm_front: tick intake and command classification
// Takes one tick per beat, decodes the op and prepares the byte to shift.
// ============================================================================
module i2cm_front
    import i2cm_pkg::*;
(
    input  logic       i_in_valid,
    input  logic       i_cmd_valid,
    input  logic [2:0] i_op,
    input  logic [7:0] i_tx_byte,
    input  logic       i_send_ack,
    input  logic [6:0] i_target_address,
    input  logic       i_is_write,
    input  logic       i_sda_in,
    input  logic       i_scl_in,
    input  logic       i_full,
    output logic       o_in_stall,
    output logic       o_push,
    output t_item      o_item
);

    t_cmd       cmd;
    logic [7:0] data;

    always_comb begin
        cmd  = CMD_NONE;
        data = BYTE_ONES;
        if (i_cmd_valid) begin
            case (i_op)
                OP_START: cmd = CMD_START;
                OP_STOP:  cmd = CMD_STOP;
                OP_WRITE: begin
                    cmd  = CMD_WRITE;
                    data = i_tx_byte;
                end
                OP_READ:  cmd = CMD_READ;
                OP_ADDR:  begin
                    cmd  = CMD_ADDR;
                    data = {i_target_address, ~i_is_write};
                end
                default:  cmd = CMD_NONE;
            endcase
        end
    end

    assign o_in_stall     = i_full;
    assign o_push         = i_in_valid & ~i_full;
    assign o_item.cmd      = cmd;
    assign o_item.data     = data;
    assign o_item.send_ack = i_send_ack;
    assign o_item.sda      = i_sda_in;
    assign o_item.scl      = i_scl_in;

endmodule

/* hdl/i2cm_queue.sv */
`timescale 1ns / 1ps
// ============================================================================
// i2cm_queue: short tick queue between front and back
// Small register FIFO; push and pop may happen in the same cycle.
// ============================================================================
module i2cm_queue
    import i2cm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_valid,
    output t_item o_item
);

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              do_pop;

    assign do_pop  = i_pop & (r_count != '0);
    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? QPTR_W'(r_wr_ptr + 1'b1) : r_wr_ptr;
        n_rd_ptr = do_pop ? QPTR_W'(r_rd_ptr + 1'b1) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !do_pop) begin
            n_count = QCNT_W'(r_count + 1'b1);
        end else if (!i_push && do_pop) begin
            n_count = QCNT_W'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

/* hdl/i2cm_back.sv */
`timescale 1ns / 1ps
// ============================================================================
// i2cm_back: bus sequencer and result register
// Steps the start/stop/byte state machine once per tick and holds the result.
// ============================================================================
module i2cm_back
    import i2cm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_q_valid,
    input  t_item      i_q_item,
    output logic       o_pop,
    input  logic       i_out_stall,
    output logic       o_out_valid,
    output logic       o_scl_out,
    output logic       o_sda_out,
    output logic       o_busy_res,
    output logic       o_done_res,
    output logic [7:0] o_rx_byte,
    output logic       o_nack_seen,
    output logic       o_start_seen
);

    typedef enum logic [10:0] {
        PH_IDLE   = 11'b000_0000_0001,
        PH_S_WAIT = 11'b000_0000_0010,
        PH_S_HOLD = 11'b000_0000_0100,
        PH_S_SAMP = 11'b000_0000_1000,
        PH_P_WAIT = 11'b000_0001_0000,
        PH_P_T4   = 11'b000_0010_0000,
        PH_P_T2   = 11'b000_0100_0000,
        PH_X_LOW  = 11'b000_1000_0000,
        PH_X_WAIT = 11'b001_0000_0000,
        PH_X_HIGH = 11'b010_0000_0000,
        PH_X_TAIL = 11'b100_0000_0000
    } t_phase;

    t_phase             r_phase,     n_phase;
    logic [TIMER_W-1:0] r_timer,     n_timer;
    logic [3:0]         r_bit_idx,   n_bit_idx;
    logic [7:0]         r_shift,     n_shift;
    logic               r_is_read,   n_is_read;
    logic               r_ack,       n_ack;
    logic               r_nack,      n_nack;
    logic               r_start,     n_start;
    logic [7:0]         r_rx,        n_rx;
    logic               r_scl_drv,   n_scl_drv;
    logic               r_sda_drv,   n_sda_drv;
    logic               r_prev_sda,  n_prev_sda;
    logic               r_prev_scl,  n_prev_scl;
    logic               r_done,      n_done;
    logic               r_out_valid, n_out_valid;

    logic               step;
    logic               expired;
    logic [TIMER_W-1:0] half_load;
    logic [TIMER_W-1:0] high_load;
    logic [3:0]         bit_next;

    // A zero register value counts as one tick
    function automatic logic [TIMER_W-1:0] load_val(input logic [TIMER_W-1:0] v);
        return (v == '0) ? TIMER_W'(1) : v;
    endfunction

    assign step      = i_q_valid & (~r_out_valid | ~i_out_stall);
    assign o_pop     = step;
    assign expired   = (r_timer <= TIMER_W'(1));
    assign half_load = load_val(i_cfg.half_period);
    assign high_load = load_val(i_cfg.high_hold);
    assign bit_next  = r_bit_idx + 4'd1;

    always_comb begin
        n_phase    = r_phase;
        n_timer    = r_timer;
        n_bit_idx  = r_bit_idx;
        n_shift    = r_shift;
        n_is_read  = r_is_read;
        n_ack      = r_ack;
        n_nack     = r_nack;
        n_start    = r_start;
        n_rx       = r_rx;
        n_scl_drv  = r_scl_drv;
        n_sda_drv  = r_sda_drv;
        n_prev_sda = r_prev_sda;
        n_prev_scl = r_prev_scl;
        n_done     = r_done;

        if (step) begin
            n_done = 1'b0;
            case (r_phase)
                PH_IDLE: begin
                    case (i_q_item.cmd)
                        CMD_START: begin
                            n_start   = 1'b0;
                            n_scl_drv = 1'b1;
                            n_sda_drv = 1'b1;
                            n_phase   = PH_S_WAIT;
                        end
                        CMD_STOP: begin
                            n_sda_drv = 1'b0;
                            n_scl_drv = 1'b1;
                            n_phase   = PH_P_WAIT;
                        end
                        CMD_WRITE, CMD_READ, CMD_ADDR: begin
                            n_shift   = i_q_item.data;
                            n_is_read = (i_q_item.cmd == CMD_READ);
                            if (i_q_item.cmd == CMD_READ) begin
                                n_ack = i_q_item.send_ack;
                            end else begin
                                n_nack = 1'b0;
                            end
                            n_bit_idx = '0;
                            n_scl_drv = 1'b0;
                            n_sda_drv = i_q_item.data[7];
                            n_timer   = half_load;
                            n_phase   = PH_X_LOW;
                        end
                        default: n_phase = PH_IDLE;
                    endcase
                end
                PH_S_WAIT: begin
                    if (i_q_item.scl) begin
                        n_timer = half_load;
                        n_phase = PH_S_HOLD;
                    end
                end
                PH_S_HOLD: begin
                    if (expired) begin
                        n_sda_drv = 1'b0;
                        n_phase   = PH_S_SAMP;
                    end else begin
                        n_timer = r_timer - TIMER_W'(1);
                    end
                end
                PH_S_SAMP: begin
                    n_scl_drv = 1'b0;
                    n_sda_drv = 1'b1;
                    n_phase   = PH_IDLE;
                    n_done    = 1'b1;
                end
                PH_P_WAIT: begin
                    if (i_q_item.scl) begin
                        n_timer = high_load;
                        n_phase = PH_P_T4;
                    end
                end
                PH_P_T4: begin
                    if (expired) begin
                        n_sda_drv = 1'b1;
                        n_timer   = half_load;
                        n_phase   = PH_P_T2;
                    end else begin
                        n_timer = r_timer - TIMER_W'(1);
                    end
                end
                PH_P_T2: begin
                    if (expired) begin
                        n_phase = PH_IDLE;
                        n_done  = 1'b1;
                    end else begin
                        n_timer = r_timer - TIMER_W'(1);
                    end
                end
                PH_X_LOW: begin
                    if (expired) begin
                        n_scl_drv = 1'b1;
                        n_phase   = PH_X_WAIT;
                    end else begin
                        n_timer = r_timer - TIMER_W'(1);
                    end
                end
                PH_X_WAIT: begin
                    if (i_q_item.scl) begin
                        if (!r_bit_idx[3]) begin
                            n_shift = {r_shift[6:0], i_q_item.sda};
                        end else if (!r_is_read) begin
                            n_nack = i_q_item.sda;
                        end
                        n_timer = high_load;
                        n_phase = PH_X_HIGH;
                    end
                end
                PH_X_HIGH: begin
                    if (expired) begin
                        n_scl_drv = 1'b0;
                        n_bit_idx = bit_next;
                        n_timer   = half_load;
                        if (!bit_next[3]) begin
                            n_sda_drv = r_shift[7];
                            n_phase   = PH_X_LOW;
                        end else if (bit_next == 4'd8) begin
                            // Ack slot: reads drive the ack, writes release SDA
                            if (r_is_read) begin
                                n_rx      = r_shift;
                                n_sda_drv = ~r_ack;
                            end else begin
                                n_sda_drv = 1'b1;
                            end
                            n_phase = PH_X_LOW;
                        end else begin
                            n_sda_drv = 1'b1;
                            n_phase   = PH_X_TAIL;
                        end
                    end else begin
                        n_timer = r_timer - TIMER_W'(1);
                    end
                end
                PH_X_TAIL: begin
                    if (expired) begin
                        n_shift = BYTE_ONES;
                        n_phase = PH_IDLE;
                        n_done  = 1'b1;
                    end else begin
                        n_timer = r_timer - TIMER_W'(1);
                    end
                end
                default: n_phase = PH_IDLE;
            endcase

            // Bus-level start: SDA falls while SCL stays high
            if (r_prev_scl && i_q_item.scl && r_prev_sda && !i_q_item.sda) begin
                n_start = 1'b1;
            end
            n_prev_sda = i_q_item.sda;
            n_prev_scl = i_q_item.scl;
        end
    end

    always_comb begin
        if (step) begin
            n_out_valid = 1'b1;
        end else if (i_out_stall) begin
            n_out_valid = r_out_valid;
        end else begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_timer     <= '0;
            r_bit_idx   <= '0;
            r_shift     <= BYTE_ONES;
            r_is_read   <= 1'b0;
            r_ack       <= 1'b1;
            r_nack      <= 1'b0;
            r_start     <= 1'b0;
            r_rx        <= '0;
            r_scl_drv   <= 1'b1;
            r_sda_drv   <= 1'b1;
            r_prev_sda  <= 1'b1;
            r_prev_scl  <= 1'b1;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_timer     <= n_timer;
            r_bit_idx   <= n_bit_idx;
            r_shift     <= n_shift;
            r_is_read   <= n_is_read;
            r_ack       <= n_ack;
            r_nack      <= n_nack;
            r_start     <= n_start;
            r_rx        <= n_rx;
            r_scl_drv   <= n_scl_drv;
            r_sda_drv   <= n_sda_drv;
            r_prev_sda  <= n_prev_sda;
            r_prev_scl  <= n_prev_scl;
            r_done      <= n_done;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_scl_out    = r_scl_drv;
    assign o_sda_out    = r_sda_drv;
    assign o_busy_res   = (r_phase != PH_IDLE);
    assign o_done_res   = r_done;
    assign o_rx_byte    = r_rx;
    assign o_nack_seen  = r_nack;
    assign o_start_seen = r_start;

endmodule

/* hdl/i2c_master_byte_engine.sv */
`timescale 1ns / 1ps
// ============================================================================
// i2c_master_byte_engine: I2C master, one bus tick per beat
// Drives open-drain SCL/SDA levels for start, stop, byte and address commands.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_stall): each beat is one tick of bus time,
//   carrying an optional command and the sampled SDA and SCL line levels.
//   Output channel (o_out_valid / i_out_stall): exactly one result beat per
//   input beat, in order: SCL/SDA drive, busy, done pulse, received byte,
//   ack status and start-detect flag after that tick.
//   Timing registers (half period, high hold) sit behind the APB port at byte
//   addresses 0 and 4; write them only while the engine is idle.
// Path and throughput:
//   A beat is written into the tick queue, then its result into the result
//   register, from which the result beat leaves. One beat per cycle is
//   sustained while i_out_stall is low; the limit is the single-step
//   sequencer in the back, which retires one tick per cycle.
// Reset (synchronous, active low): sequencer idle, both lines released, the
//   tick queue and result register empty, timing registers at 47 and 40.
// Stall: while i_out_stall is high and a result is valid, that result holds and
//   the sequencer freezes; the front keeps taking ticks into the 4-entry queue
//   until it fills, then raises o_in_stall.
// ============================================================================
module i2c_master_byte_engine
    import i2cm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // tick input channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_cmd_valid,
    input  logic [2:0]        i_op,
    input  logic [7:0]        i_tx_byte,
    input  logic              i_send_ack,
    input  logic [6:0]        i_target_address,
    input  logic              i_is_write,
    input  logic              i_sda_in,
    input  logic              i_scl_in,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_scl_out,
    output logic              o_sda_out,
    output logic              o_busy_res,
    output logic              o_done_res,
    output logic [7:0]        o_rx_byte,
    output logic              o_nack_seen,
    output logic              o_start_seen,
    // register port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic [TIMER_W-1:0] r_half_period;
    logic [TIMER_W-1:0] r_high_hold;
    logic               cfg_wr;
    t_cfg               cfg;

    logic               push;
    t_item              push_item;
    logic               q_full;
    logic               q_valid;
    t_item              q_item;
    logic               pop;

    // Register file: write on the access phase, paddr bit 2 picks the word
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= HALF_PERIOD_RST;
            r_high_hold   <= HIGH_HOLD_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_HALF_PERIOD) begin
                r_half_period <= pwdata[TIMER_W-1:0];
            end else begin
                r_high_hold <= pwdata[TIMER_W-1:0];
            end
        end
    end

    always_comb begin
        case (paddr[2])
            REG_HALF_PERIOD: prdata = APB_DW'(r_half_period);
            REG_HIGH_HOLD:   prdata = APB_DW'(r_high_hold);
            default:         prdata = '0;
        endcase
    end

    assign cfg.half_period = r_half_period;
    assign cfg.high_hold   = r_high_hold;

    // Front: accept ticks and classify commands
    i2cm_front u_front (
        .i_in_valid       (i_in_valid),
        .i_cmd_valid      (i_cmd_valid),
        .i_op             (i_op),
        .i_tx_byte        (i_tx_byte),
        .i_send_ack       (i_send_ack),
        .i_target_address (i_target_address),
        .i_is_write       (i_is_write),
        .i_sda_in         (i_sda_in),
        .i_scl_in         (i_scl_in),
        .i_full           (q_full),
        .o_in_stall       (o_in_stall),
        .o_push           (push),
        .o_item           (push_item)
    );

    // Decouple intake from the sequencer
    i2cm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    // Back: step the bus sequencer, hold the result beat
    i2cm_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_q_valid    (q_valid),
        .i_q_item     (q_item),
        .o_pop        (pop),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_scl_out    (o_scl_out),
        .o_sda_out    (o_sda_out),
        .o_busy_res   (o_busy_res),
        .o_done_res   (o_done_res),
        .o_rx_byte    (o_rx_byte),
        .o_nack_seen  (o_nack_seen),
        .o_start_seen (o_start_seen)
    );

endmodule

/* hdl/i2cm_checker.sv */
`timescale 1ns / 1ps
// ============================================================================
// i2cm_checker: port-level checks of the I2C master byte engine
// Watches the result channel for hold, idle-line, done/busy and post-reset consistency.
// ============================================================================
module i2cm_checker
    import i2cm_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic       o_scl_out,
    input logic       o_sda_out,
    input logic       o_busy_res,
    input logic       o_done_res,
    input logic [7:0] o_rx_byte
);

    // Hold a stalled result beat
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_scl_out)
            && $stable(o_sda_out) && $stable(o_rx_byte))
        else $error("stalled result beat changed");

    // A completing command leaves the engine idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_done_res |-> !o_busy_res)
        else $error("done reported while busy");

    // SDA is released in every valid result beat that shows the engine idle
    a_idle_sda: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_busy_res |-> o_sda_out)
        else $error("SDA held low while idle");

    // No result beat right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind i2c_master_byte_engine i2cm_checker u_i2cm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_scl_out   (o_scl_out),
    .o_sda_out   (o_sda_out),
    .o_busy_res  (o_busy_res),
    .o_done_res  (o_done_res),
    .o_rx_byte   (o_rx_byte)
);
